// ===== rtl/core/ffda_pkg.sv =====
`timescale 1ns / 1ps

package ffda_pkg;

   localparam int ELEMENTS_DEFAULT = 4096;

   localparam logic [1:0] CMD_ACCUM      = 2'd0;
   localparam logic [1:0] CMD_READ       = 2'd1;
   localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] velocity;
      logic [16:0]        porosity;
      logic [31:0]        area;
      logic [11:0]        plus_elem;
      logic               plus_valid;
      logic [11:0]        minus_elem;
      logic               minus_valid;
      logic [11:0]        read_index;
   } req_payload_type;

   typedef struct packed {
      logic signed [47:0] face_flux;
      logic signed [47:0] elem_value;
      logic               saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic               sat;
      logic signed [47:0] value;
   } sat_val_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FLUX,
      ST_PLUS,
      ST_MINUS,
      ST_READ,
      ST_DONE
   } state_type;

   // clamp a wide sum to the signed 48-bit range
   function automatic sat_val_type sat48(input logic signed [50:0] x);
      sat_val_type r;
      r.sat   = (x[50:47] != 4'b0000) && (x[50:47] != 4'b1111);
      r.value = r.sat ? (x[50] ? ACC_MIN : ACC_MAX) : x[47:0];
      return r;
   endfunction

endpackage

// ===== rtl/core/ffda_chan_if.sv =====
`timescale 1ns / 1ps

interface ffda_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/ffda_flux_unit.sv =====
`timescale 1ns / 1ps

module ffda_flux_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [31:0]     velocity,
   input  logic [16:0]            porosity,
   input  logic [31:0]            area,
   output ffda_pkg::sat_val_type  result,
   output logic                   done
);
   import ffda_pkg::*;

   logic [2:0]         vld_ff, vld_in;
   logic signed [48:0] prod_ff, prod_in;
   logic [31:0]        area_ff, area_in;
   logic signed [49:0] hi_ff, hi_in, lo_ff, lo_in;
   sat_val_type        res_ff, res_in;

   logic signed [49:0] prod_full;
   logic signed [32:0] t;
   logic signed [49:0] hi_full, lo_full;
   logic signed [50:0] sum;

   // stage one: porosity times velocity
   assign prod_full = $signed({1'b0, porosity}) * velocity;
   assign prod_in   = start ? prod_full[48:0] : prod_ff;
   assign area_in   = start ? area : area_ff;

   // stage two: floored product times area halves
   assign t       = prod_ff[48:16];
   assign hi_full = t * $signed({1'b0, area_ff[31:16]});
   assign lo_full = t * $signed({1'b0, area_ff[15:0]});
   assign hi_in   = vld_ff[0] ? hi_full : hi_ff;
   assign lo_in   = vld_ff[0] ? lo_full : lo_ff;

   // stage three: recombine and clamp
   assign sum    = {hi_ff[49], hi_ff} + {{17{lo_ff[49]}}, lo_ff[49:16]};
   assign res_in = vld_ff[1] ? sat48(sum) : res_ff;

   assign vld_in = {vld_ff[1:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      area_ff <= area_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      res_ff  <= res_in;
   end

   assign result = res_ff;
   assign done   = vld_ff[2];

endmodule

// ===== rtl/core/ffda_acc_ram.sv =====
`timescale 1ns / 1ps

module ffda_acc_ram #(
   parameter int DEPTH = ffda_pkg::ELEMENTS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [47:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [47:0]   rd_data
);

   logic [47:0] acc_mem [DEPTH];
   logic [47:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         acc_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= acc_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/face_flux_divergence_accumulator.sv =====
`timescale 1ns / 1ps

// Finite-volume divergence scatter-add over one accumulator RAM of ELEMENTS
// signed 48-bit entries. One beat is taken at a time. An accumulate beat passes
// through the porosity/velocity/area multiplier chain, then two read-modify-write
// passes through the single write port of the RAM, one for each neighbour, then
// a step that loads the output register. A read or read-and-clear beat does one
// RAM read (and clear) before that load, and an unused command code goes straight
// to it. The next beat is taken after the output register is loaded. A new beat
// is taken while the previous result still waits in the output register. After
// reset the block zeroes the RAM one entry per cycle, so it accepts no beat until
// every entry is cleared.
module face_flux_divergence_accumulator #(
   parameter int ELEMENTS = ffda_pkg::ELEMENTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   ffda_chan_if.sink    req_if,
   ffda_chan_if.source  rsp_if
);
   import ffda_pkg::*;

   localparam int AW = $clog2(ELEMENTS);

   state_type          state_ff, state_in;
   req_payload_type    item_ff, item_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic signed [47:0] res_flux_ff, res_flux_in;
   logic signed [47:0] res_value_ff, res_value_in;
   logic               res_sat_ff, res_sat_in;
   logic signed [47:0] plus_sum_ff, plus_sum_in;
   logic               out_valid_ff, out_valid_in;
   rsp_payload_type    out_ff, out_in;

   logic               accept;
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [47:0]        wr_data, rd_data;
   logic               flux_start, flux_done;
   sat_val_type        flux_res;
   logic               plus_ok, minus_ok, read_ok, same_elem;
   logic signed [47:0] minus_base;
   logic signed [50:0] plus_wide, minus_wide;
   sat_val_type        plus_upd, minus_upd;

   ffda_flux_unit u_flux (
      .clock    (clock),
      .reset    (reset),
      .start    (flux_start),
      .velocity (req_if.payload.velocity),
      .porosity (req_if.payload.porosity),
      .area     (req_if.payload.area),
      .result   (flux_res),
      .done     (flux_done)
   );

   ffda_acc_ram #(
      .DEPTH (ELEMENTS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept = req_if.valid && req_if.ready;
   assign item_in = accept ? req_if.payload : item_ff;

   assign plus_ok   = item_ff.plus_valid && (32'(item_ff.plus_elem) < ELEMENTS);
   assign minus_ok  = item_ff.minus_valid && (32'(item_ff.minus_elem) < ELEMENTS);
   assign read_ok   = 32'(item_ff.read_index) < ELEMENTS;
   assign same_elem = item_ff.plus_elem == item_ff.minus_elem;

   // forward the plus-side write when both sides hit one entry
   assign minus_base = (plus_ok && same_elem) ? plus_sum_ff : rd_data;
   assign plus_wide  = {{3{rd_data[47]}}, rd_data} + {{3{res_flux_ff[47]}}, res_flux_ff};
   assign minus_wide = {{3{minus_base[47]}}, minus_base}
                       - {{3{res_flux_ff[47]}}, res_flux_ff};
   assign plus_upd   = sat48(plus_wide);
   assign minus_upd  = sat48(minus_wide);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(ELEMENTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_if.payload.cmd)
                  CMD_ACCUM:      state_in = ST_FLUX;
                  CMD_READ:       state_in = ST_READ;
                  CMD_READ_CLEAR: state_in = ST_READ;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_FLUX: begin
            if (flux_done) state_in = ST_PLUS;
         end
         ST_PLUS:  state_in = ST_MINUS;
         ST_MINUS: state_in = ST_DONE;
         ST_READ:  state_in = ST_DONE;
         ST_DONE: begin
            if (!out_valid_ff || rsp_if.ready) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_if.ready = state_ff == ST_IDLE;
      flux_start   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      rd_addr      = AW'(req_if.payload.read_index);
      clr_in       = clr_ff;
      res_flux_in  = res_flux_ff;
      res_value_in = res_value_ff;
      res_sat_in   = res_sat_ff;
      plus_sum_in  = plus_sum_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               flux_start   = req_if.payload.cmd == CMD_ACCUM;
               res_flux_in  = '0;
               res_value_in = '0;
               res_sat_in   = 1'b0;
            end
         end
         ST_FLUX: begin
            rd_addr = AW'(item_ff.plus_elem);
            if (flux_done) begin
               res_flux_in = flux_res.value;
               res_sat_in  = flux_res.sat;
            end
         end
         ST_PLUS: begin
            rd_addr     = AW'(item_ff.minus_elem);
            wr_en       = plus_ok;
            wr_addr     = AW'(item_ff.plus_elem);
            wr_data     = plus_upd.value;
            plus_sum_in = plus_upd.value;
            res_sat_in  = res_sat_ff || (plus_ok && plus_upd.sat);
         end
         ST_MINUS: begin
            wr_en      = minus_ok;
            wr_addr    = AW'(item_ff.minus_elem);
            wr_data    = minus_upd.value;
            res_sat_in = res_sat_ff || (minus_ok && minus_upd.sat);
         end
         ST_READ: begin
            res_value_in = read_ok ? $signed(rd_data) : '0;
            wr_en        = read_ok && (item_ff.cmd == CMD_READ_CLEAR);
            wr_addr      = AW'(item_ff.read_index);
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_if.ready) begin
               out_in.face_flux  = res_flux_ff;
               out_in.elem_value = res_value_ff;
               out_in.saturated  = res_sat_ff;
               out_valid_in      = 1'b1;
            end
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      res_flux_ff  <= res_flux_in;
      res_value_ff <= res_value_in;
      res_sat_ff   <= res_sat_in;
      plus_sum_ff  <= plus_sum_in;
      out_ff       <= out_in;
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_ff;

`ifndef SYNTHESIS
   a_no_write_when_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE || state_ff == ST_FLUX) |-> !wr_en)
      else $error("accumulator write outside an update state");

   a_flux_done_in_flux: assert property (@(posedge clock) disable iff (reset)
      flux_done |-> state_ff == ST_FLUX)
      else $error("flux result arrived outside the flux wait");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised without a finished beat");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |=>
         (state_ff == ST_IDLE) || (clr_ff == $past(clr_ff) + AW'(1)))
      else $error("clearing pass skipped an entry");

   a_flux_clamp: assert property (@(posedge clock) disable iff (reset)
      (flux_done && flux_res.sat) |->
         (flux_res.value == ACC_MAX) || (flux_res.value == ACC_MIN))
      else $error("saturated flux not at a range limit");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ffda_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ELEMENTS = ELEMENTS_DEFAULT;
   localparam int STALL_LIMIT = 12000;
   localparam int RANDOM_PER_PHASE = 550;

   class divergence_ledger;
      logic signed [47:0] sums [ELEMENTS];
      rsp_payload_type due [$];
      int errors;

      function new();
         foreach (sums[i]) sums[i] = '0;
         errors = 0;
      endfunction

      function logic signed [79:0] widen(input logic signed [47:0] x);
         return {{32{x[47]}}, x};
      endfunction

      function logic signed [47:0] clamp48(input logic signed [79:0] x, inout logic sat);
         if (x > 80'sh7FFF_FFFF_FFFF) begin
            sat = 1'b1;
            return ACC_MAX;
         end
         if (x < -80'sh8000_0000_0000) begin
            sat = 1'b1;
            return ACC_MIN;
         end
         return x[47:0];
      endfunction

      function void note_req(input req_payload_type r);
         rsp_payload_type res;
         logic signed [79:0] v, p, a, t, f;
         logic sat;
         res = '0;
         sat = 1'b0;
         case (r.cmd)
            CMD_ACCUM: begin
               v = {{48{r.velocity[31]}}, r.velocity};
               p = {63'd0, r.porosity};
               a = {48'd0, r.area};
               t = (p * v) >>> 16;
               f = (t * a) >>> 16;
               res.face_flux = clamp48(f, sat);
               if (r.plus_valid && r.plus_elem < ELEMENTS)
                  sums[r.plus_elem] = clamp48(widen(sums[r.plus_elem]) + widen(res.face_flux),
                                              sat);
               if (r.minus_valid && r.minus_elem < ELEMENTS)
                  sums[r.minus_elem] = clamp48(widen(sums[r.minus_elem]) - widen(res.face_flux),
                                               sat);
               res.saturated = sat;
            end
            CMD_READ, CMD_READ_CLEAR: begin
               if (r.read_index < ELEMENTS) begin
                  res.elem_value = sums[r.read_index];
                  if (r.cmd == CMD_READ_CLEAR) sums[r.read_index] = '0;
               end
            end
            default: begin
            end
         endcase
         due.push_back(res);
      endfunction

      function void check_rsp(input rsp_payload_type got);
         rsp_payload_type want;
         if (due.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual flux %h value %h sat %b",
                     $time, got.face_flux, got.elem_value, got.saturated);
            errors++;
            return;
         end
         want = due.pop_front();
         if (got.face_flux !== want.face_flux) begin
            $display("%0t face_flux: expected %h, actual %h", $time, want.face_flux,
                     got.face_flux);
            errors++;
         end
         if (got.elem_value !== want.elem_value) begin
            $display("%0t elem_value: expected %h, actual %h", $time, want.elem_value,
                     got.elem_value);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t saturated: expected %b, actual %b", $time, want.saturated,
                     got.saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int req_idle_pct;
   int rsp_idle_pct;
   int idle_cycles;

   ffda_chan_if #(.payload_type(req_payload_type)) req_if ();
   ffda_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   divergence_ledger ledger = new();

   face_flux_divergence_accumulator dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial rsp_if.ready = 1'b0;

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // beat monitor and stall watchdog
   initial idle_cycles = 0;

   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready) ledger.check_rsp(rsp_if.payload);
      if (req_if.valid && req_if.ready) ledger.note_req(req_if.payload);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic req_payload_type make_req(input logic [1:0] cmd,
                                                input logic [31:0] velocity,
                                                input logic [16:0] porosity,
                                                input logic [31:0] area,
                                                input logic [11:0] plus_elem,
                                                input logic plus_valid,
                                                input logic [11:0] minus_elem,
                                                input logic minus_valid,
                                                input logic [11:0] read_index);
      req_payload_type r;
      r.cmd = cmd;
      r.velocity = velocity;
      r.porosity = porosity;
      r.area = area;
      r.plus_elem = plus_elem;
      r.plus_valid = plus_valid;
      r.minus_elem = minus_elem;
      r.minus_valid = minus_valid;
      r.read_index = read_index;
      return r;
   endfunction

   function automatic logic [11:0] pick_elem();
      if ($urandom_range(99) < 75) return 12'($urandom_range(0, 7));
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic req_payload_type random_face();
      req_payload_type r;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) r.cmd = CMD_ACCUM;
      else if (pick < 84) r.cmd = CMD_READ;
      else if (pick < 97) r.cmd = CMD_READ_CLEAR;
      else r.cmd = CMD_UNUSED;
      if ($urandom_range(2) == 0)
         r.velocity = $signed(32'($urandom_range(0, 2 ** 21))) - 32'sd1048576;
      else
         r.velocity = $urandom();
      if ($urandom_range(9) == 0) r.porosity = 17'($urandom_range(0, 131071));
      else r.porosity = 17'($urandom_range(0, 65536));
      if ($urandom_range(1) == 0) r.area = 32'($urandom_range(0, 2 ** 20));
      else r.area = $urandom();
      r.plus_elem = pick_elem();
      r.plus_valid = ($urandom_range(9) != 0);
      r.minus_elem = pick_elem();
      r.minus_valid = ($urandom_range(9) != 0);
      r.read_index = pick_elem();
      return r;
   endfunction

   // every call starts and ends at a falling edge
   task automatic send_req(input req_payload_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (ledger.due.size() != 0) @(negedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_req(random_face());
   endtask

   initial begin
      req_payload_type opening [$];
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      req_idle_pct = 17;
      rsp_idle_pct = 82;

      // zero, extremes, porosity above one, truncation toward minus infinity,
      // same element on both sides, absent neighbours, accumulator clamping
      opening.push_back(make_req(CMD_READ, 32'h0, 17'd0, 32'h0, 12'd0, 1'b0, 12'd0, 1'b0, 12'd0));
      opening.push_back(make_req(CMD_ACCUM, 32'h7FFF_FFFF, 17'd65536, 32'hFFFF_FFFF,
                                 12'd1, 1'b1, 12'd2, 1'b1, 12'd0));
      opening.push_back(make_req(CMD_ACCUM, 32'h8000_0000, 17'd65536, 32'hFFFF_FFFF,
                                 12'd4095, 1'b1, 12'd0, 1'b1, 12'd0));
      opening.push_back(make_req(CMD_ACCUM, 32'h7FFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF,
                                 12'd3, 1'b1, 12'd3, 1'b1, 12'd0));
      opening.push_back(make_req(CMD_ACCUM, 32'h8000_0000, 17'h1FFFF, 32'hFFFF_FFFF,
                                 12'd5, 1'b1, 12'd6, 1'b0, 12'd0));
      opening.push_back(make_req(CMD_ACCUM, 32'hFFFF_FFFF, 17'd1, 32'h1,
                                 12'd7, 1'b1, 12'd8, 1'b1, 12'd0));
      opening.push_back(make_req(CMD_ACCUM, 32'h1234_5678, 17'd0, 32'hFFFF_FFFF,
                                 12'd7, 1'b1, 12'd8, 1'b1, 12'd0));
      opening.push_back(make_req(CMD_ACCUM, 32'h0001_0000, 17'd65536, 32'h0,
                                 12'd7, 1'b1, 12'd8, 1'b1, 12'd0));
      opening.push_back(make_req(CMD_ACCUM, 32'h0001_0000, 17'd32768, 32'h0003_0000,
                                 12'd9, 1'b0, 12'd10, 1'b0, 12'd0));
      repeat (2) opening.push_back(make_req(CMD_ACCUM, 32'h7FFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF,
                                            12'd11, 1'b1, 12'd0, 1'b0, 12'd0));
      repeat (2) opening.push_back(make_req(CMD_ACCUM, 32'h8000_0000, 17'h1FFFF, 32'hFFFF_FFFF,
                                            12'd0, 1'b0, 12'd12, 1'b1, 12'd0));
      opening.push_back(make_req(CMD_READ, 32'h0, 17'd0, 32'h0, 12'd0, 1'b0, 12'd0, 1'b0, 12'd11));
      opening.push_back(make_req(CMD_READ_CLEAR, 32'h0, 17'd0, 32'h0, 12'd0, 1'b0, 12'd0, 1'b0,
                                 12'd11));
      opening.push_back(make_req(CMD_READ, 32'h0, 17'd0, 32'h0, 12'd0, 1'b0, 12'd0, 1'b0, 12'd11));
      opening.push_back(make_req(CMD_READ_CLEAR, 32'h0, 17'd0, 32'h0, 12'd0, 1'b0, 12'd0, 1'b0,
                                 12'd12));
      opening.push_back(make_req(CMD_READ, 32'h0, 17'd0, 32'h0, 12'd0, 1'b0, 12'd0, 1'b0, 12'd4095));
      opening.push_back(make_req(CMD_READ, 32'h0, 17'd0, 32'h0, 12'd0, 1'b0, 12'd0, 1'b0, 12'd3));
      opening.push_back(make_req(CMD_READ, 32'h0, 17'd0, 32'h0, 12'd0, 1'b0, 12'd0, 1'b0, 12'd5));
      opening.push_back(make_req(CMD_UNUSED, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF,
                                 12'hFFF, 1'b1, 12'hFFF, 1'b1, 12'hFFF));
      opening.push_back(make_req(CMD_READ_CLEAR, 32'h0, 17'd0, 32'h0, 12'd0, 1'b0, 12'd0, 1'b0,
                                 12'hFFF));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening[i]) send_req(opening[i]);
      send_random(RANDOM_PER_PHASE);
      drain_results();

      req_idle_pct = 82;
      rsp_idle_pct = 17;
      send_random(RANDOM_PER_PHASE);
      drain_results();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random(RANDOM_PER_PHASE);
      drain_results();

      repeat (12) @(posedge clock);
      if (ledger.due.size() != 0) ledger.errors++;
      if (ledger.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ffda_pkg.sv
rtl/core/ffda_chan_if.sv
rtl/core/ffda_flux_unit.sv
rtl/core/ffda_acc_ram.sv
rtl/core/face_flux_divergence_accumulator.sv
tb/sv/testbench.sv
